// ===== design/base64url_unpadded_codec_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the base64url codec unit
// Each macro samples on clk and is disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef BASE64URL_UNPADDED_CODEC_UNIT_ASSERT_SVH
`define BASE64URL_UNPADDED_CODEC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64U_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64u same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define B64U_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64u next-cycle check failed");

`endif

// ===== design/b64u_pkg.sv =====
// ---------------------------------------------------------------------------
// b64u_pkg
// Item types, job format and character tables of the base64url codec.
// ---------------------------------------------------------------------------
package b64u_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam int JOBQ_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_DANGLING = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;
  } out_item_t;

  // One group of results: up to four characters or three bytes taken
  // from the top of word, or a single flag result with a zero byte.
  typedef struct packed {
    logic [23:0] word;
    logic        is_char;
    logic [1:0]  last_idx;
    logic        last;
    logic [1:0]  status;
  } job_t;

  // Bit 6 set marks a character outside the alphabet.
  function automatic logic [6:0] char_value(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b0, 6'(c - 8'd71)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c + 8'd4)};
    end else if (c == 8'h2D) begin
      r = 7'd62;
    end else if (c == 8'h5F) begin
      r = 7'd63;
    end else begin
      r = 7'h40;
    end
    return r;
  endfunction

  function automatic logic [7:0] enc_char(input logic [5:0] i);
    logic [7:0] r;
    if (i < 6'd26) begin
      r = 8'h41 + {2'b00, i};
    end else if (i < 6'd52) begin
      r = {2'b00, i} + 8'd71;
    end else if (i < 6'd62) begin
      r = {2'b00, i} - 8'd4;
    end else if (i == 6'd62) begin
      r = 8'h2D;
    end else begin
      r = 8'h5F;
    end
    return r;
  endfunction

endpackage

// ===== design/b64u_front.sv =====
// ---------------------------------------------------------------------------
// b64u_front
// Accepts input items, tracks the partial group and turns each completed
// group, tail or error into one job for the back end.
// ---------------------------------------------------------------------------
module b64u_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  b64u_pkg::in_item_t item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  output logic             job_push,
  output b64u_pkg::job_t   job,
  input  logic             job_full
);
  import b64u_pkg::*;

  logic        direction;
  logic [17:0] held;
  logic [1:0]  group_count;
  logic        stopped;

  logic [17:0] held_next;
  logic [1:0]  group_count_next;
  logic        stopped_next;
  logic        emit;
  logic        accept;
  logic [6:0]  dval;
  logic [7:0]  b;
  logic        lst;

  assign full      = job_full;
  assign cfg_ready = 1'b1;
  assign accept    = push && !job_full;
  assign job_push  = accept && emit;
  assign b         = item.data_byte;
  assign lst       = item.last;
  assign dval      = char_value(b);

  always_comb begin
    emit             = 1'b0;
    job              = '0;
    held_next        = 18'd0;
    group_count_next = 2'd0;
    stopped_next     = 1'b0;
    job.last         = lst;
    job.status       = ST_OK;
    if (direction == DIR_ENCODE) begin
      job.is_char = 1'b1;
      if (group_count == 2'd2) begin
        emit          = 1'b1;
        job.word      = {held[15:0], b};
        job.last_idx  = 2'd3;
      end else if (lst && group_count == 2'd0) begin
        emit          = 1'b1;
        job.word      = {b, 16'h0000};
        job.last_idx  = 2'd1;
      end else if (lst) begin
        emit          = 1'b1;
        job.word      = {held[7:0], b, 8'h00};
        job.last_idx  = 2'd2;
      end else begin
        held_next        = {held[9:0], b};
        group_count_next = group_count + 2'd1;
      end
    end else if (stopped) begin
      // swallow the rest of the stream, flag once at its end
      if (lst) begin
        emit       = 1'b1;
        job.status = ST_INVALID;
      end else begin
        stopped_next = 1'b1;
      end
    end else if (dval[6]) begin
      emit         = 1'b1;
      job.status   = ST_INVALID;
      stopped_next = !lst;
    end else if (group_count == 2'd3) begin
      emit         = 1'b1;
      job.word     = {held, dval[5:0]};
      job.last_idx = 2'd2;
    end else if (lst && group_count == 2'd0) begin
      emit       = 1'b1;
      job.status = ST_DANGLING;
    end else if (lst && group_count == 2'd1) begin
      emit         = 1'b1;
      job.word     = {held[5:0], dval[5:0], 12'h000};
      job.last_idx = 2'd0;
    end else if (lst) begin
      emit         = 1'b1;
      job.word     = {held[11:0], dval[5:0], 6'h00};
      job.last_idx = 2'd1;
    end else begin
      held_next        = {held[11:0], dval[5:0]};
      group_count_next = group_count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= DIR_ENCODE;
      held        <= 18'd0;
      group_count <= 2'd0;
      stopped     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      // abandon any stream in progress
      direction   <= cfg_data;
      held        <= 18'd0;
      group_count <= 2'd0;
      stopped     <= 1'b0;
    end else if (accept) begin
      held        <= held_next;
      group_count <= group_count_next;
      stopped     <= stopped_next;
    end
  end

endmodule

// ===== design/b64u_jobq.sv =====
// ---------------------------------------------------------------------------
// b64u_jobq
// Short job queue between front end and back end.
// ---------------------------------------------------------------------------
module b64u_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  b64u_pkg::job_t wdata,
  output logic           full,
  input  logic           rd,
  output logic           rvalid,
  output b64u_pkg::job_t rdata
);
  import b64u_pkg::*;

  localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOBQ_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(JOBQ_DEPTH);

  job_t             slots [JOBQ_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] cnt;
  logic             do_wr;
  logic             do_rd;

  assign full   = (cnt == CNT_FULL);
  assign rvalid = (cnt != '0);
  assign rdata  = slots[rptr];
  assign do_wr  = wr && !full;
  assign do_rd  = rd && rvalid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== design/b64u_back.sv =====
// ---------------------------------------------------------------------------
// b64u_back
// Expands each job into result items in an output register, one per cycle while that register is free or popped.
// ---------------------------------------------------------------------------
`include "base64url_unpadded_codec_unit_assert.svh"

module b64u_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  b64u_pkg::job_t      job,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output b64u_pkg::out_item_t result
);
  import b64u_pkg::*;

  job_t      cur;
  logic      busy;
  logic [1:0] k;
  logic      ov;
  out_item_t ob;
  out_item_t cur_item;
  logic      out_free;
  logic      finishing;
  logic      load_job;
  logic [5:0] six;
  logic [7:0] byte_sel;

  assign out_free  = !ov || pop;
  assign finishing = busy && out_free && (k == cur.last_idx);
  assign load_job  = job_valid && (!busy || finishing);
  assign job_pop   = load_job;
  assign empty     = !ov;
  assign result    = ob;

  always_comb begin
    case (k)
      2'd0:    six = cur.word[23:18];
      2'd1:    six = cur.word[17:12];
      2'd2:    six = cur.word[11:6];
      default: six = cur.word[5:0];
    endcase
    case (k)
      2'd0:    byte_sel = cur.word[23:16];
      2'd1:    byte_sel = cur.word[15:8];
      default: byte_sel = cur.word[7:0];
    endcase
    cur_item.out_byte = cur.is_char ? enc_char(six) : byte_sel;
    cur_item.out_last = cur.last && (k == cur.last_idx);
    cur_item.status   = cur.status;
  end

  always_ff @(posedge clk) begin
    if (busy && out_free) begin
      ob <= cur_item;
    end
    if (load_job) begin
      cur <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= 2'd0;
      ov   <= 1'b0;
    end else begin
      // output register holds until popped, refills from the running job
      if (out_free) begin
        ov <= busy;
      end
      if (busy && out_free) begin
        k <= k + 2'd1;
        if (k == cur.last_idx) begin
          busy <= 1'b0;
        end
      end
      if (load_job) begin
        busy <= 1'b1;
        k    <= 2'd0;
      end
    end
  end

  `B64U_ASSERT_SAME(a_index_in_range, busy, k <= cur.last_idx)
  `B64U_ASSERT_SAME(a_flag_job_single, load_job && job.status != ST_OK,
                    job.last_idx == 2'd0 && !job.is_char)
  `B64U_ASSERT_NEXT(a_emit_fills_output, busy && out_free, !empty)

endmodule

// ===== design/base64url_unpadded_codec_unit.sv =====
// ---------------------------------------------------------------------------
// base64url_unpadded_codec_unit
// Streaming base64url codec without padding, encode or decode by register.
// ---------------------------------------------------------------------------
// Input side is a queue: present item with push, it is taken when full is
// low. Results come out of a queue: while empty is low the oldest result is
// on result, pop takes it. cfg_valid/cfg_data write the direction bit
// (0 encode, 1 decode); cfg_ready is always high and a write drops any
// partial group. Write it only while the unit is drained.
// A result passes the job queue, the back end's job register and the output
// register before it shows. The back end emits one result per cycle while
// results are popped, so decode takes one character per cycle and encode
// three bytes per four results, a rate the output register and expander set.
// The front end keeps taking items while fewer than two jobs wait in the job
// queue; a stalled receiver fills that queue and then raises full.
// Reset clears the direction to encode, drops all partial state and empties
// both queues.
// ---------------------------------------------------------------------------
module base64url_unpadded_codec_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  b64u_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output b64u_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import b64u_pkg::*;

  logic job_push;
  job_t job_in;
  logic job_full;
  logic job_pop;
  logic job_valid;
  job_t job_out;

  b64u_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  b64u_jobq u_jobq (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wdata  (job_in),
    .full   (job_full),
    .rd     (job_pop),
    .rvalid (job_valid),
    .rdata  (job_out)
  );

  b64u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
